/* hdl/mvna_pkg.sv */
// Shared constants for the mesh vertex normal accumulator.
// Sizes, op codes, result kinds and sequencer state codes.
// No dependencies.
package mvna_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int VIDX_W       = $clog2(MAX_VERTICES);
    localparam int VCNT_W       = 11;
    localparam int SUM_W        = 24;
    localparam int POS_W        = 32;
    localparam int NORM_W       = 16;
    localparam int NORM_ONE_SH  = 14;

    localparam logic [VCNT_W-1:0] VCNT_RESET = VCNT_W'(1024);
    localparam logic [VCNT_W-1:0] VCNT_MAX   = VCNT_W'(MAX_VERTICES);

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_FACE = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic KIND_FACE   = 1'b0;
    localparam logic KIND_VERTEX = 1'b1;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_FA   = 4'd2;
    localparam logic [3:0] S_FB   = 4'd3;
    localparam logic [3:0] S_FC   = 4'd4;
    localparam logic [3:0] S_FD   = 4'd5;
    localparam logic [3:0] S_MUL  = 4'd6;
    localparam logic [3:0] S_MAG  = 4'd7;
    localparam logic [3:0] S_SHR  = 4'd8;
    localparam logic [3:0] S_SQ   = 4'd9;
    localparam logic [3:0] S_SQRT = 4'd10;
    localparam logic [3:0] S_DINI = 4'd11;
    localparam logic [3:0] S_DIV  = 4'd12;
    localparam logic [3:0] S_ACR  = 4'd13;
    localparam logic [3:0] S_ACW  = 4'd14;
    localparam logic [3:0] S_DONE = 4'd15;

endpackage

/* hdl/mesh_vertex_normal_accumulator_core.sv */
// Mesh vertex normal accumulator: vertex store, normal sums and a sequenced
// fixed-point unit-normal engine. Depends on mvna_pkg.
// Steps: a load is written at its accepting edge; a bad index goes to
//   the result. A face forms its cross product; it, or a read from its
//   sum, shifts one bit per cycle to reduce range, takes a 32-step square
//   root, then unless degenerate divides thrice and, for a face, accumulates.
// Throughput: one item at a time; a finished word waits in the output
//   register while the next item is taken. A stalled word holds the sequencer.
// Reset: asynchronous, active low. Afterwards the normal sums are cleared by
//   one pass over all entries, taking no item (APB writes still work).
module mesh_vertex_normal_accumulator_core
    import mvna_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // APB register port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [0:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    // input words
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               op,
    input  logic [VIDX_W-1:0]        vertex_index,
    input  logic signed [POS_W-1:0]  pos_x,
    input  logic signed [POS_W-1:0]  pos_y,
    input  logic signed [POS_W-1:0]  pos_z,
    input  logic [VIDX_W-1:0]        corner_a,
    input  logic [VIDX_W-1:0]        corner_b,
    input  logic [VIDX_W-1:0]        corner_c,
    // result words
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     kind,
    output logic signed [NORM_W-1:0] norm_x,
    output logic signed [NORM_W-1:0] norm_y,
    output logic signed [NORM_W-1:0] norm_z,
    output logic                     degenerate,
    output logic                     bad_index
);

    // ---------------------------------------------------------------
    // Register file
    // ---------------------------------------------------------------
    logic [VCNT_W-1:0] vcount_reg;
    logic [VCNT_W-1:0] limit;

    assign pready = 1'b1;
    assign prdata = {{(32-VCNT_W){1'b0}}, vcount_reg};
    assign limit  = (vcount_reg > VCNT_MAX) ? VCNT_MAX : vcount_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vcount_reg <= VCNT_RESET;
        else if (psel && penable && pwrite && pready && paddr == 1'b0)
            vcount_reg <= pwdata[VCNT_W-1:0];
    end

    // ---------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------
    logic [3:0]        state_reg, state_next;
    logic [4:0]        cnt_reg;
    logic [1:0]        k_reg;
    logic [VIDX_W-1:0] clr_reg;
    logic              res_valid_reg;
    logic              in_acc;
    logic              out_free;

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !res_valid_reg || !out_stall;

    // index checks against the live vertex count
    logic bad_vi, bad_face;
    assign bad_vi   = {1'b0, vertex_index} >= limit;
    assign bad_face = ({1'b0, corner_a} >= limit) || ({1'b0, corner_b} >= limit)
                   || ({1'b0, corner_c} >= limit);

    // ---------------------------------------------------------------
    // Datapath registers
    // ---------------------------------------------------------------
    logic [VIDX_W-1:0]        ca_reg, cb_reg, cc_reg;
    logic [3*POS_W-1:0]       p_reg, q_reg;
    logic signed [POS_W-1:0]  d_reg [6];
    logic signed [63:0]       comp_reg [3];
    logic [63:0]              mag_reg [3];
    logic                     neg_reg [3];
    logic signed [63:0]       prod_reg;
    logic [63:0]              sq_reg;
    logic [63:0]              sv_reg, sr_reg, sb_reg;
    logic [31:0]              rem_reg;
    logic [14:0]              nlow_reg;
    logic [14:0]              quo_reg;
    logic signed [NORM_W-1:0] n_reg [3];
    logic                     kind_reg, degen_reg, bad_reg;

    // output register
    logic                     o_kind_reg, o_degen_reg, o_bad_reg;
    logic signed [NORM_W-1:0] o_nx_reg, o_ny_reg, o_nz_reg;

    assign out_valid  = res_valid_reg;
    assign kind       = o_kind_reg;
    assign norm_x     = o_nx_reg;
    assign norm_y     = o_ny_reg;
    assign norm_z     = o_nz_reg;
    assign degenerate = o_degen_reg;
    assign bad_index  = o_bad_reg;

    // ---------------------------------------------------------------
    // Memories: positions and normal sums, registered reads
    // ---------------------------------------------------------------
    logic [3*POS_W-1:0] vmem [MAX_VERTICES];
    logic [3*SUM_W-1:0] smem [MAX_VERTICES];
    logic [3*POS_W-1:0] vrd_reg;
    logic [3*SUM_W-1:0] srd_reg;
    logic [VIDX_W-1:0]  v_raddr, s_raddr, s_waddr, acc_addr;
    logic [3*SUM_W-1:0] s_wdata;
    logic               s_we, v_we;

    always_comb
    begin
        unique case (k_reg)
            2'd0:    acc_addr = ca_reg;
            2'd1:    acc_addr = cb_reg;
            default: acc_addr = cc_reg;
        endcase
    end

    always_comb
    begin
        unique case (state_reg)
            S_FB:    v_raddr = cb_reg;
            S_FC:    v_raddr = cc_reg;
            default: v_raddr = ca_reg;
        endcase
    end

    // idle reads the addressed sum so a read item has it on entering S_ACR
    assign s_raddr = (state_reg == S_ACR)  ? acc_addr :
                     (state_reg == S_IDLE) ? vertex_index : ca_reg;
    assign v_we    = in_acc && op == OP_LOAD && !bad_vi;

    // saturating add of the face normal into the sum of one corner
    logic signed [SUM_W:0]   sat_s [3];
    logic signed [SUM_W-1:0] sat_r [3];
    localparam logic signed [SUM_W:0] SAT_HI = (SUM_W+1)'((1 << (SUM_W-1)) - 1);
    localparam logic signed [SUM_W:0] SAT_LO = -SAT_HI - (SUM_W+1)'(1);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sat_s[i] = (SUM_W+1)'(signed'(srd_reg[i*SUM_W +: SUM_W]))
                     + (SUM_W+1)'(n_reg[i]);
            if (sat_s[i] > SAT_HI)
                sat_r[i] = SAT_HI[SUM_W-1:0];
            else if (sat_s[i] < SAT_LO)
                sat_r[i] = SAT_LO[SUM_W-1:0];
            else
                sat_r[i] = sat_s[i][SUM_W-1:0];
        end
    end

    always_comb
    begin
        s_we    = 1'b0;
        s_waddr = vertex_index;
        s_wdata = '0;
        if (state_reg == S_CLR)
        begin
            s_we    = 1'b1;
            s_waddr = clr_reg;
        end
        else if (v_we)
            s_we = 1'b1;
        else if (state_reg == S_ACW)
        begin
            s_we    = 1'b1;
            s_waddr = acc_addr;
            s_wdata = {sat_r[2], sat_r[1], sat_r[0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (v_we)
            vmem[vertex_index] <= {pos_z, pos_y, pos_x};
        vrd_reg <= vmem[v_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
            smem[s_waddr] <= s_wdata;
        srd_reg <= smem[s_raddr];
    end

    // ---------------------------------------------------------------
    // Shared multiplier, one product a cycle
    // ---------------------------------------------------------------
    logic signed [31:0] mul_a, mul_b;
    logic [1:0]         comp_idx;

    // component that the product now in prod_reg belongs to
    assign comp_idx = 2'((cnt_reg - 5'd1) >> 1);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_MUL)
        begin
            // cross product terms in pairs: x, y, z
            unique case (cnt_reg[2:0])
                3'd0:    begin mul_a = d_reg[1]; mul_b = d_reg[5]; end
                3'd1:    begin mul_a = d_reg[2]; mul_b = d_reg[4]; end
                3'd2:    begin mul_a = d_reg[2]; mul_b = d_reg[3]; end
                3'd3:    begin mul_a = d_reg[0]; mul_b = d_reg[5]; end
                3'd4:    begin mul_a = d_reg[0]; mul_b = d_reg[4]; end
                3'd5:    begin mul_a = d_reg[1]; mul_b = d_reg[3]; end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
        else if (state_reg == S_SQ)
        begin
            unique case (cnt_reg[1:0])
                2'd0:    begin mul_a = {2'b0, mag_reg[0][29:0]}; end
                2'd1:    begin mul_a = {2'b0, mag_reg[1][29:0]}; end
                2'd2:    begin mul_a = {2'b0, mag_reg[2][29:0]}; end
                default: begin mul_a = '0; end
            endcase
            mul_b = mul_a;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // ---------------------------------------------------------------
    // Edge differences q-p and r-p, halved together when any reaches 2^31
    // ---------------------------------------------------------------
    logic signed [POS_W:0] dif [6];
    logic [POS_W:0]        dmag [6];
    logic                  dshift;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dif[i]   = (POS_W+1)'(signed'(q_reg[i*POS_W +: POS_W]))
                     - (POS_W+1)'(signed'(p_reg[i*POS_W +: POS_W]));
            dif[3+i] = (POS_W+1)'(signed'(vrd_reg[i*POS_W +: POS_W]))
                     - (POS_W+1)'(signed'(p_reg[i*POS_W +: POS_W]));
        end
        dshift = 1'b0;
        for (int i = 0; i < 6; i++)
        begin
            dmag[i] = dif[i][POS_W] ? (POS_W+1)'(-dif[i]) : (POS_W+1)'(dif[i]);
            dshift  = dshift | dmag[i][31];
        end
    end

    // ---------------------------------------------------------------
    // Square root step and division step
    // ---------------------------------------------------------------
    logic [63:0] sq_t;
    logic [30:0] len;
    logic [31:0] div_t;
    logic [44:0] div_n;
    logic [63:0] big_or;

    assign sq_t   = sr_reg + sb_reg;
    assign len    = sr_reg[30:0];
    assign div_t  = {rem_reg[30:0], nlow_reg[14]};
    assign div_n  = {1'b0, mag_reg[k_reg][29:0], {NORM_ONE_SH{1'b0}}}
                  + {14'b0, 1'b0, len[30:1]};
    assign big_or = mag_reg[0] | mag_reg[1] | mag_reg[2];

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:  if (clr_reg == VIDX_W'(MAX_VERTICES - 1)) state_next = S_IDLE;
            S_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (op)
                        OP_LOAD: state_next = bad_vi ? S_DONE : S_IDLE;
                        OP_FACE: state_next = bad_face ? S_DONE : S_FA;
                        OP_READ: state_next = bad_vi ? S_DONE : S_ACR;
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_FA:   state_next = S_FB;
            S_FB:   state_next = S_FC;
            S_FC:   state_next = S_FD;
            S_FD:   state_next = S_MUL;
            S_MUL:  if (cnt_reg == 5'd6) state_next = S_MAG;
            S_MAG:  state_next = S_SHR;
            S_SHR:  if (big_or[63:30] == '0) state_next = S_SQ;
            S_SQ:   if (cnt_reg == 5'd3) state_next = S_SQRT;
            S_SQRT:
            begin
                if (cnt_reg == 5'd31)
                    state_next = S_DINI;
            end
            S_DINI: state_next = (sr_reg == '0) ? S_DONE : S_DIV;
            S_DIV:
            begin
                if (cnt_reg == 5'd14)
                begin
                    if (k_reg != 2'd2)
                        state_next = S_DINI;
                    else if (kind_reg == KIND_FACE)
                        state_next = S_ACR;
                    else
                        state_next = S_DONE;
                end
            end
            // a read item also passes S_ACR to pick up its sum
            S_ACR:  state_next = (kind_reg == KIND_FACE) ? S_ACW : S_MAG;
            S_ACW:  state_next = (k_reg == 2'd2) ? S_DONE : S_ACR;
            S_DONE: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            k_reg         <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLR)
                clr_reg <= clr_reg + VIDX_W'(1);

            unique case (state_reg)
                S_MUL, S_SQ, S_SQRT, S_DIV:
                    cnt_reg <= (state_next == state_reg) ? cnt_reg + 5'd1 : '0;
                default:
                    cnt_reg <= '0;
            endcase

            if (state_reg == S_IDLE)
                k_reg <= '0;
            else if (state_reg == S_DIV && cnt_reg == 5'd14)
                k_reg <= (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
            else if (state_reg == S_ACW)
                k_reg <= k_reg + 2'd1;

            if (state_reg == S_DONE && out_free)
                res_valid_reg <= 1'b1;
            else if (!out_stall)
                res_valid_reg <= 1'b0;
        end
    end

    // datapath updates
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                kind_reg  <= (op == OP_FACE) ? KIND_FACE : KIND_VERTEX;
                bad_reg   <= (op == OP_FACE) ? bad_face : bad_vi;
                degen_reg <= 1'b0;
                ca_reg    <= (op == OP_FACE) ? corner_a : vertex_index;
                cb_reg    <= corner_b;
                cc_reg    <= corner_c;
                for (int i = 0; i < 3; i++)
                    n_reg[i] <= '0;
            end
            S_FB: p_reg <= vrd_reg;
            S_FC: q_reg <= vrd_reg;
            S_FD:
            begin
                for (int i = 0; i < 6; i++)
                begin
                    if (dif[i][POS_W])
                        d_reg[i] <= -signed'(POS_W'(dmag[i] >> dshift));
                    else
                        d_reg[i] <= signed'(POS_W'(dmag[i] >> dshift));
                end
            end
            S_MUL:
            begin
                if (cnt_reg != 5'd0)
                begin
                    if (cnt_reg[0])
                        comp_reg[comp_idx] <= prod_reg;
                    else
                        comp_reg[comp_idx] <= comp_reg[comp_idx] - prod_reg;
                end
            end
            S_ACR:
            begin
                if (kind_reg == KIND_VERTEX)
                    for (int i = 0; i < 3; i++)
                        comp_reg[i] <= 64'(signed'(srd_reg[i*SUM_W +: SUM_W]));
            end
            S_MAG:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    neg_reg[i] <= comp_reg[i][63];
                    mag_reg[i] <= comp_reg[i][63] ? 64'(-comp_reg[i]) : 64'(comp_reg[i]);
                end
                sq_reg <= '0;
            end
            S_SHR:
            begin
                if (big_or[63:30] != '0)
                    for (int i = 0; i < 3; i++)
                        mag_reg[i] <= mag_reg[i] >> 1;
            end
            S_SQ:
            begin
                if (cnt_reg != 5'd0)
                    sq_reg <= sq_reg + 64'(prod_reg);
                sv_reg <= sq_reg + 64'(prod_reg);
                sr_reg <= '0;
                sb_reg <= 64'd1 << 62;
            end
            S_SQRT:
            begin
                if (sv_reg >= sq_t)
                begin
                    sv_reg <= sv_reg - sq_t;
                    sr_reg <= (sr_reg >> 1) + sb_reg;
                end
                else
                    sr_reg <= sr_reg >> 1;
                sb_reg <= sb_reg >> 2;
            end
            S_DINI:
            begin
                if (sr_reg == '0)
                    degen_reg <= 1'b1;
                rem_reg  <= {2'b0, div_n[44:15]};
                nlow_reg <= div_n[14:0];
                quo_reg  <= '0;
            end
            S_DIV:
            begin
                if (div_t >= {1'b0, len})
                begin
                    rem_reg <= div_t - {1'b0, len};
                    quo_reg <= {quo_reg[13:0], 1'b1};
                end
                else
                begin
                    rem_reg <= div_t;
                    quo_reg <= {quo_reg[13:0], 1'b0};
                end
                nlow_reg <= {nlow_reg[13:0], 1'b0};
                if (cnt_reg == 5'd14)
                begin
                    if (neg_reg[k_reg])
                        n_reg[k_reg] <= -signed'({quo_reg, (div_t >= {1'b0, len})});
                    else
                        n_reg[k_reg] <= signed'({quo_reg, (div_t >= {1'b0, len})});
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    o_kind_reg  <= kind_reg;
                    o_degen_reg <= degen_reg;
                    o_bad_reg   <= bad_reg;
                    o_nx_reg    <= n_reg[0];
                    o_ny_reg    <= n_reg[1];
                    o_nz_reg    <= n_reg[2];
                end
            end
            default: ;
        endcase
    end

endmodule
